>>> hw/rtl/trq_pkg.sv
// Shared types, constants and helpers for the timed release queue.
`timescale 1ns / 1ps
package trq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int TAG_BITS    = 16;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = 6;
    localparam int TIME_W  = 48;
    localparam int REL_W   = TIME_W + 1;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int TAG_W   = 16;
    localparam int KIND_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_DELIVERED = 3'd0,
        KIND_EXPIRED   = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_ACCEPTED  = 3'd3,
        KIND_REJECTED  = 3'd4,
        KIND_IGNORED   = 3'd5
    } kind_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE = 2'd0,
        REG_DELAY  = 2'd1,
        REG_TTL    = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    localparam logic CMD_INGEST = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_POP_RD,
        ST_POP_DUE,
        ST_POP_AGE,
        ST_POP_TTL,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [REL_W-1:0]    release_time;
        logic [TIME_W-1:0]   rx_time;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // physical slot of a logical queue position, modulo the depth
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

>>> hw/rtl/trq_ifs.sv
// Handshake channel interfaces: event input, result output, register writes.
`timescale 1ns / 1ps
interface trq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [trq_pkg::TAG_W-1:0]   event_tag;
    logic [trq_pkg::TIME_W-1:0]  receive_time;
    logic [trq_pkg::TIME_W-1:0]  current_time;

    modport source (output valid, command, event_tag, receive_time, current_time,
                    input ready);
    modport sink   (input valid, command, event_tag, receive_time, current_time,
                    output ready);
endinterface

interface trq_out_if;
    logic                        valid;
    logic                        ready;
    logic [trq_pkg::KIND_W-1:0]  kind;
    logic [trq_pkg::TAG_W-1:0]   out_tag;
    logic [trq_pkg::TIME_W-1:0]  out_receive_time;
    logic                        last;
    logic [trq_pkg::CNT_W-1:0]   pending_count;
    logic [trq_pkg::CFG_W-1:0]   delivered_total;
    logic [trq_pkg::CFG_W-1:0]   expired_total;

    modport source (output valid, kind, out_tag, out_receive_time, last, pending_count,
                    delivered_total, expired_total, input ready);
    modport sink   (input valid, kind, out_tag, out_receive_time, last, pending_count,
                    delivered_total, expired_total, output ready);
endinterface

interface trq_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [trq_pkg::IDX_W-1:0]   index;
    logic [trq_pkg::CFG_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/trq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module trq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/timed_release_queue_with_ttl_unit.sv
// Top level: time-ordered release queue with expiry, one shared adder/comparator.
//
//  channel | dir | payload                                         | accepted when
//  --------+-----+-------------------------------------------------+--------------
//  ev      | in  | command, event_tag, receive_time, current_time  | valid & ready
//  res     | out | kind, out_tag, out_receive_time, last, pending, | valid & ready
//          |     | delivered_total, expired_total                  |
//  cfg     | in  | index, data                                     | valid & ready
//
//  One word at a time. A disabled or full-queue word goes straight to its result word.
//  Ingest: add the delay to receive_time, then walk backward through the entry RAM,
//  shifting up each queued entry with a later release time. Tick: for each released
//  entry read, due compare, age subtract and ttl compare on the shared unit; then
//  the done word when the queue is empty or its head is not yet due.
//  Reset empties the queue and clears the totals; entry RAM contents are not cleared.
//  A stalled result output holds the sequencer at its next result; ev may be
//  taken again once the sequencer is idle, even while a result waits in res.
`timescale 1ns / 1ps
module timed_release_queue_with_ttl_unit (
    input logic clk,
    input logic rst_n,
    trq_in_if.sink    ev,
    trq_out_if.source res,
    trq_cfg_if.sink   cfg
);
    import trq_pkg::*;

    state_t              state_reg, state_next;
    logic                enable_reg;
    logic [CFG_W-1:0]    delay_reg, ttl_reg;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PTR_W-1:0]    walk_reg, walk_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [TIME_W-1:0]   rx_reg, rx_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [REL_W-1:0]    rel_reg, rel_next;
    logic [TIME_W-1:0]   diff_reg, diff_next;
    logic                age_pos_reg, age_pos_next;
    kind_t               kind_reg, kind_next;
    logic [CFG_W-1:0]    delivered_reg, delivered_next;
    logic [CFG_W-1:0]    expired_reg, expired_next;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [TIME_W-1:0]   out_rx_reg;
    logic                out_last_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [CFG_W-1:0]    out_dlv_reg, out_exp_reg;

    logic                load_out;
    kind_t               load_kind;
    logic [TAG_W-1:0]    load_tag;
    logic [TIME_W-1:0]   load_rx;
    logic                load_last;
    logic [CNT_W-1:0]    load_count;
    logic                out_free;

    // shared add/subtract unit
    logic [REL_W-1:0]    ua, ub;
    logic                usub;
    logic [REL_W:0]      usum;
    logic [REL_W-1:0]    ures;
    logic                uborrow;

    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr, ram_raddr;
    entry_t              ram_wdata, ram_rdata;
    entry_t              new_entry;
    logic                ev_acc;
    logic                expired;

    trq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign usum    = {1'b0, ua} + {1'b0, (usub ? ~ub : ub)} + {{REL_W{1'b0}}, usub};
    assign ures    = usum[REL_W-1:0];
    assign uborrow = usub & ~usum[REL_W];

    assign ev.ready  = (state_reg == ST_IDLE);
    assign ev_acc    = ev.valid & ev.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = ~out_valid_reg | res.ready;

    assign new_entry.release_time = rel_reg;
    assign new_entry.rx_time      = rx_reg;
    assign new_entry.tag          = tag_reg;

    // ttl - age borrows when age exceeds ttl
    assign expired = (ttl_reg != '0) & age_pos_reg & uborrow;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        tag_next       = tag_reg;
        rx_next        = rx_reg;
        now_next       = now_reg;
        rel_next       = rel_reg;
        diff_next      = diff_reg;
        age_pos_next   = age_pos_reg;
        kind_next      = kind_reg;
        delivered_next = delivered_reg;
        expired_next   = expired_reg;

        ua   = '0;
        ub   = '0;
        usub = 1'b1;

        ram_we    = 1'b0;
        ram_waddr = wrap_add(head_reg, walk_reg);
        ram_wdata = new_entry;
        ram_raddr = head_reg;

        load_out   = 1'b0;
        load_kind  = kind_reg;
        load_tag   = '0;
        load_rx    = '0;
        load_last  = 1'b1;
        load_count = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ev_acc)
                begin
                    tag_next = TAG_BITS'(ev.event_tag);
                    rx_next  = ev.receive_time;
                    now_next = ev.current_time;
                    if (!enable_reg)
                    begin
                        kind_next  = KIND_IGNORED;
                        state_next = ST_FINAL;
                    end
                    else if (ev.command == CMD_INGEST)
                    begin
                        if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            kind_next  = KIND_REJECTED;
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            kind_next  = KIND_ACCEPTED;
                            state_next = ST_ADD;
                        end
                    end
                    else
                    begin
                        kind_next  = KIND_DONE;
                        state_next = ST_POP_RD;
                    end
                end
            end

            ST_ADD:
            begin
                ua        = {1'b0, rx_reg};
                ub        = REL_W'(delay_reg);
                usub      = 1'b0;
                rel_next  = ures;
                walk_next = count_reg[PTR_W-1:0];
                ram_raddr = wrap_add(head_reg, count_reg[PTR_W-1:0] - 1'b1);
                state_next = (count_reg == '0) ? ST_INS_PUT : ST_INS_CMP;
            end

            ST_INS_CMP:
            begin
                // read data is the entry at logical walk-1
                ua = rel_reg;
                ub = ram_rdata.release_time;
                ram_we = 1'b1;
                if (uborrow)
                begin
                    // later release: shift it up one slot
                    ram_wdata = ram_rdata;
                    walk_next = walk_reg - 1'b1;
                    ram_raddr = wrap_add(head_reg, walk_reg - PTR_W'(2));
                    if (walk_reg == PTR_W'(1))
                    begin
                        state_next = ST_INS_PUT;
                    end
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_FINAL;
                end
            end

            ST_INS_PUT:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = ST_FINAL;
            end

            ST_POP_RD:
            begin
                state_next = (count_reg == '0) ? ST_FINAL : ST_POP_DUE;
            end

            ST_POP_DUE:
            begin
                ua = {1'b0, now_reg};
                ub = ram_rdata.release_time;
                state_next = uborrow ? ST_FINAL : ST_POP_AGE;
            end

            ST_POP_AGE:
            begin
                ua = {1'b0, now_reg};
                ub = {1'b0, ram_rdata.rx_time};
                diff_next    = ures[TIME_W-1:0];
                age_pos_next = ~uborrow & (ures != '0);
                state_next   = ST_POP_TTL;
            end

            ST_POP_TTL:
            begin
                ua = REL_W'(ttl_reg);
                ub = {1'b0, diff_reg};
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_tag   = TAG_W'(ram_rdata.tag);
                    load_rx    = ram_rdata.rx_time;
                    load_last  = 1'b0;
                    load_count = count_reg - 1'b1;
                    count_next = count_reg - 1'b1;
                    head_next  = wrap_add(head_reg, PTR_W'(1));
                    if (expired)
                    begin
                        load_kind = KIND_EXPIRED;
                        if (expired_reg != '1)
                        begin
                            expired_next = expired_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        load_kind = KIND_DELIVERED;
                        if (delivered_reg != '1)
                        begin
                            delivered_next = delivered_reg + 1'b1;
                        end
                    end
                    state_next = ST_POP_RD;
                end
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            delay_reg     <= '0;
            ttl_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            delivered_reg <= '0;
            expired_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            delivered_reg <= delivered_next;
            expired_reg   <= expired_next;
            if (cfg.valid)
            begin
                unique case (reg_idx_t'(cfg.index))
                    REG_ENABLE: enable_reg <= cfg.data[0];
                    REG_DELAY:  delay_reg  <= cfg.data;
                    REG_TTL:    ttl_reg    <= cfg.data;
                    REG_NONE:   ;
                    default:    ;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and result word, no reset needed
    always_ff @(posedge clk)
    begin
        walk_reg    <= walk_next;
        tag_reg     <= tag_next;
        rx_reg      <= rx_next;
        now_reg     <= now_next;
        rel_reg     <= rel_next;
        diff_reg    <= diff_next;
        age_pos_reg <= age_pos_next;
        kind_reg    <= kind_next;
        if (load_out)
        begin
            out_kind_reg  <= load_kind;
            out_tag_reg   <= load_tag;
            out_rx_reg    <= load_rx;
            out_last_reg  <= load_last;
            out_count_reg <= load_count;
            out_dlv_reg   <= delivered_next;
            out_exp_reg   <= expired_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.kind             = out_kind_reg;
    assign res.out_tag          = out_tag_reg;
    assign res.out_receive_time = out_rx_reg;
    assign res.last             = out_last_reg;
    assign res.pending_count    = out_count_reg;
    assign res.delivered_total  = out_dlv_reg;
    assign res.expired_total    = out_exp_reg;

endmodule
